// ----- sv/mbet_pkg.sv -----
// Constants and helpers for the Mandelbrot escape-time pixel engine.
// Fixed-point formats, register indexes and colour mapping.
// No dependencies.
`default_nettype none

package mbet_pkg;

  // Orbit limit and divisor clamp
  localparam int MAX_ITERATIONS = 100;
  localparam int MAX_SIDE       = 4096;

  // Q4.28 coordinates
  localparam int FRAC_BITS = 28;

  // Restoring divider: quotient magnitude of 12-bit index times 32-bit span
  localparam int DIV_BITS = 44;

  // Configuration register indexes
  localparam logic [2:0] CFG_RE_START     = 3'd0;
  localparam logic [2:0] CFG_RE_END       = 3'd1;
  localparam logic [2:0] CFG_IM_START     = 3'd2;
  localparam logic [2:0] CFG_IM_END       = 3'd3;
  localparam logic [2:0] CFG_IMAGE_WIDTH  = 3'd4;
  localparam logic [2:0] CFG_IMAGE_HEIGHT = 3'd5;

  // Reset values of the axis registers
  localparam logic [31:0] RE_START_RST = 32'hE000_0000; // -2.0
  localparam logic [31:0] RE_END_RST   = 32'h1000_0000; //  1.0
  localparam logic [31:0] IM_START_RST = 32'hF000_0000; // -1.0
  localparam logic [31:0] IM_END_RST   = 32'h1000_0000; //  1.0
  localparam logic [12:0] SIDE_RST     = 13'd1920;

  // x / MAX_ITERATIONS for x below 2^17 as a multiply by a rounded-up reciprocal
  localparam int          RECIP_SHIFT = 25;
  localparam logic [25:0] RECIP = 26'(((64'd1 << RECIP_SHIFT) + 64'(MAX_ITERATIONS) - 64'd1)
                                      / 64'(MAX_ITERATIONS));

  function automatic logic [17:0] div_max(input logic [16:0] x);
    logic [42:0] p;
    p = 43'(x) * 43'(RECIP);
    return p[42:RECIP_SHIFT];
  endfunction

  // floor(510*n/MAX), saturated at 255
  function automatic logic [7:0] chan_dbl(input logic [7:0] n);
    logic [17:0] q;
    q = div_max(17'(n) * 17'd510);
    return (q > 18'd255) ? 8'hFF : q[7:0];
  endfunction

  // floor(255*n/MAX), saturated at 255
  function automatic logic [7:0] chan_lin(input logic [7:0] n);
    logic [17:0] q;
    q = div_max(17'(n) * 17'd255);
    return (q > 18'd255) ? 8'hFF : q[7:0];
  endfunction

endpackage

`default_nettype wire

// ----- sv/mandelbrot_escape_time_pixel.sv -----
// Mandelbrot escape-time pixel engine: pixel to c mapping, orbit iteration
// and colouring under one sequencer. Uses mbet_pkg.
`default_nettype none

// One pixel (row, col) is taken at a time; in_stall stays high until the
// result has been handed to the output register. Bit-serial restoring
// dividers map row and column onto the axes (both axes in parallel),
// setup and saturation steps follow, and each orbit step runs on the
// shared complex squarer (products in one state, escape test and update
// in the next). The result register lets the next pixel start while a
// finished word waits to be taken. Configuration writes are always ready
// and must be made while idle.
module mandelbrot_escape_time_pixel (
  input  wire logic               clk,
  input  wire logic               rst,
  // pixel in
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [11:0]        row,
  input  wire logic [11:0]        col,
  // result out
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [11:0]             row_out,
  output logic [11:0]             col_out,
  output logic [7:0]              escape_count,
  output logic [7:0]              chan0,
  output logic [7:0]              chan1,
  output logic [7:0]              chan2,
  // configuration
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MAP  = 8'b0000_0010,
    S_DIV  = 8'b0000_0100,
    S_FIX  = 8'b0000_1000,
    S_CADD = 8'b0001_0000,
    S_MUL  = 8'b0010_0000,
    S_STEP = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  localparam int          DB      = mbet_pkg::DIV_BITS;
  localparam int          CW      = $clog2(DB);
  localparam logic [CW-1:0] DIV_LAST = CW'(DB - 1);
  localparam logic [7:0]  MAX_N   = 8'(mbet_pkg::MAX_ITERATIONS);
  localparam logic signed [62:0] ESC_LIM = 63'sd1 <<< (2 * mbet_pkg::FRAC_BITS + 2);
  localparam logic signed [33:0] Z_LIM   = 34'sd1 <<< (mbet_pkg::FRAC_BITS + 1);
  localparam logic signed [45:0] C_MAXV  = 46'sd2147483647;
  localparam logic signed [45:0] C_MINV  = -46'sd2147483648;

  state_t state;

  // configuration registers
  logic signed [31:0] re_org, re_end, im_org, im_end;
  logic [12:0]        img_w, img_h;

  // span magnitudes and signs, tracked from the registers
  logic [31:0] span_re, span_im;
  logic        neg_re, neg_im;
  logic signed [32:0] diff_re, diff_im;

  // pixel
  logic [11:0] row_q, col_q;

  // dividers
  logic [12:0]    div_re, div_im;
  logic [DB-1:0]  dv_re, dv_im;
  logic [12:0]    rem_re, rem_im;
  logic [CW-1:0]  cnt;
  logic [13:0]    trial_re, trial_im;
  logic           ge_re, ge_im;

  // mapped point
  logic signed [45:0] q_re, q_im;
  logic signed [31:0] c_re, c_im;
  logic signed [45:0] sum_re, sum_im;

  // orbit
  logic signed [33:0] zr, zi;
  logic signed [61:0] p_rr, p_ii, p_ri;
  logic               in_rng;
  logic [7:0]         n;
  logic               bounded;
  logic signed [61:0] sq_diff;
  logic signed [33:0] zr_next, zi_next;

  function automatic logic [12:0] clamp_side(input logic [12:0] s);
    if (s == 13'd0) begin
      return 13'd1;
    end
    if (32'(s) > mbet_pkg::MAX_SIDE) begin
      return 13'(mbet_pkg::MAX_SIDE);
    end
    return s;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [45:0] v);
    if (v > C_MAXV) begin
      return 32'sh7FFF_FFFF;
    end
    if (v < C_MINV) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);

  // configuration writes; unknown indexes fall through
  always_ff @(posedge clk) begin
    if (rst) begin
      re_org <= mbet_pkg::RE_START_RST;
      re_end <= mbet_pkg::RE_END_RST;
      im_org <= mbet_pkg::IM_START_RST;
      im_end <= mbet_pkg::IM_END_RST;
      img_w  <= mbet_pkg::SIDE_RST;
      img_h  <= mbet_pkg::SIDE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mbet_pkg::CFG_RE_START:     re_org <= cfg_data;
        mbet_pkg::CFG_RE_END:       re_end <= cfg_data;
        mbet_pkg::CFG_IM_START:     im_org <= cfg_data;
        mbet_pkg::CFG_IM_END:       im_end <= cfg_data;
        mbet_pkg::CFG_IMAGE_WIDTH:  img_w  <= cfg_data[12:0];
        mbet_pkg::CFG_IMAGE_HEIGHT: img_h  <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  assign diff_re = {re_end[31], re_end} - {re_org[31], re_org};
  assign diff_im = {im_end[31], im_end} - {im_org[31], im_org};

  // span magnitude and sign, registered from the axis registers
  always_ff @(posedge clk) begin
    neg_re  <= diff_re[32];
    neg_im  <= diff_im[32];
    span_re <= diff_re[32] ? 32'(-diff_re) : diff_re[31:0];
    span_im <= diff_im[32] ? 32'(-diff_im) : diff_im[31:0];
  end

  // one restoring step per cycle on each axis
  assign trial_re = {rem_re, dv_re[DB-1]};
  assign trial_im = {rem_im, dv_im[DB-1]};
  assign ge_re    = (trial_re >= {1'b0, div_re});
  assign ge_im    = (trial_im >= {1'b0, div_im});

  // floor of a negative quotient rounds the magnitude up
  assign sum_re = 46'(c_re) + q_re;
  assign sum_im = 46'(c_im) + q_im;

  // escape test on the registered products
  assign bounded = in_rng && ((63'(p_rr) + 63'(p_ii)) <= ESC_LIM);
  assign sq_diff = p_rr - p_ii;
  assign zr_next = 34'(sq_diff >>> mbet_pkg::FRAC_BITS) + 34'(c_re);
  assign zi_next = 34'(p_ri >>> (mbet_pkg::FRAC_BITS - 1)) + 34'(c_im);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // a word taken while S_DONE loads the next is replaced there
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            row_q  <= row;
            col_q  <= col;
            div_re <= clamp_side(img_w);
            div_im <= clamp_side(img_h);
            state  <= S_MAP;
          end
        end
        S_MAP: begin
          dv_re  <= DB'(row_q) * DB'(span_re);
          dv_im  <= DB'(col_q) * DB'(span_im);
          rem_re <= '0;
          rem_im <= '0;
          cnt    <= '0;
          state  <= S_DIV;
        end
        S_DIV: begin
          rem_re <= ge_re ? 13'(trial_re - {1'b0, div_re}) : trial_re[12:0];
          rem_im <= ge_im ? 13'(trial_im - {1'b0, div_im}) : trial_im[12:0];
          dv_re  <= {dv_re[DB-2:0], ge_re};
          dv_im  <= {dv_im[DB-2:0], ge_im};
          cnt    <= cnt + 1'b1;
          if (cnt == DIV_LAST) begin
            state <= S_FIX;
          end
        end
        S_FIX: begin
          q_re  <= neg_re ? -(46'(dv_re) + 46'(rem_re != 13'd0)) : 46'(dv_re);
          q_im  <= neg_im ? -(46'(dv_im) + 46'(rem_im != 13'd0)) : 46'(dv_im);
          c_re  <= re_org;
          c_im  <= im_org;
          state <= S_CADD;
        end
        S_CADD: begin
          c_re  <= sat32(sum_re);
          c_im  <= sat32(sum_im);
          zr    <= '0;
          zi    <= '0;
          n     <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          // shared complex squarer; operands are exact whenever in range
          p_rr   <= $signed(zr[30:0]) * $signed(zr[30:0]);
          p_ii   <= $signed(zi[30:0]) * $signed(zi[30:0]);
          p_ri   <= $signed(zr[30:0]) * $signed(zi[30:0]);
          in_rng <= (zr <= Z_LIM) && (zr >= -Z_LIM) && (zi <= Z_LIM) && (zi >= -Z_LIM);
          state  <= S_STEP;
        end
        S_STEP: begin
          if (bounded && (n < MAX_N)) begin
            zr    <= zr_next;
            zi    <= zi_next;
            n     <= n + 1'b1;
            state <= S_MUL;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            row_out      <= row_q;
            col_out      <= col_q;
            escape_count <= n;
            chan0        <= mbet_pkg::chan_dbl(n);
            chan1        <= mbet_pkg::chan_lin(n);
            chan2        <= mbet_pkg::chan_lin(n);
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a pixel taken in closes the input until its result is out
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input open right after a pixel was taken");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> (n <= MAX_N))
    else $error("iteration count past the limit");

  a_result_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((escape_count <= MAX_N) && (chan0 >= chan1)))
    else $error("result word out of range");

  // a new word is loaded only when the output register is free or draining
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(escape_count)))
    else $error("waiting result word lost or changed");

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench for the Mandelbrot escape-time pixel engine.
// Predicts count and colour bytes per pixel in 64-bit fixed point and checks
// every result word. Depends on mbet_pkg and mandelbrot_escape_time_pixel.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 7;
  localparam int HOLD_CYCLES    = 800;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES    = 2 * mbet_pkg::MAX_ITERATIONS + 100;
  localparam int RANDOM_PHASES  = 20;
  localparam int RANDOM_ITEMS   = 920;
  localparam int PRINT_CAP      = 50;

  // register indexes the block does not decode
  localparam logic [2:0] CFG_SPARE_6 = 3'd6;
  localparam logic [2:0] CFG_SPARE_7 = 3'd7;

  localparam longint Q_MAX   = 64'sh0000_0000_7FFF_FFFF;
  localparam longint Q_MIN   = -64'sh0000_0000_8000_0000;
  localparam longint ESC_LIM = 64'sh0000_0000_2000_0000;  // 2.0 in Q28
  localparam longint ESC_R2  = 64'sh0400_0000_0000_0000;  // 4.0 in Q56

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HALF,
    STALL_HEAVY
  } stall_mode_t;

  typedef struct packed {
    logic [11:0] row;
    logic [11:0] col;
    logic [7:0]  steps;
    logic [7:0]  shade0;
    logic [7:0]  shade1;
    logic [7:0]  shade2;
  } pixel_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [11:0] row;
  logic [11:0] col;
  logic        out_valid;
  logic        out_stall;
  logic [11:0] row_out;
  logic [11:0] col_out;
  logic [7:0]  escape_count;
  logic [7:0]  chan0;
  logic [7:0]  chan1;
  logic [7:0]  chan2;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  mandelbrot_escape_time_pixel DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .row          (row),
    .col          (col),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .row_out      (row_out),
    .col_out      (col_out),
    .escape_count (escape_count),
    .chan0        (chan0),
    .chan1        (chan1),
    .chan2        (chan2),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // shadow copy of the window registers
  longint      cur_re_start = longint'($signed(mbet_pkg::RE_START_RST));
  longint      cur_re_end   = longint'($signed(mbet_pkg::RE_END_RST));
  longint      cur_im_start = longint'($signed(mbet_pkg::IM_START_RST));
  longint      cur_im_end   = longint'($signed(mbet_pkg::IM_END_RST));
  logic [12:0] cur_width    = mbet_pkg::SIDE_RST;
  logic [12:0] cur_height   = mbet_pkg::SIDE_RST;

  pixel_result_t pending_pixels[$];
  pixel_result_t want;

  int unsigned errors      = 0;
  int unsigned pixels_sent = 0;
  int unsigned writes_done = 0;
  int unsigned limit_hits  = 0;
  int unsigned early_exits = 0;
  int unsigned holds_done  = 0;
  bit          hold_req    = 1'b0;

  function automatic int unsigned clamp_side(input logic [12:0] side);
    if (side == 13'd0) return 1;
    if (side > mbet_pkg::MAX_SIDE) return mbet_pkg::MAX_SIDE;
    return 32'(side);
  endfunction

  // start + floor(idx * span / div), saturated to the Q4.28 range
  function automatic longint axis_point(input longint origin, input longint stop,
                                        input longint idx, input int unsigned div);
    longint d, num, q, pt;
    d   = div;
    num = idx * (stop - origin);
    if (num >= 0) q = num / d;
    else q = -((-num + d - 1) / d);
    pt = origin + q;
    if (pt > Q_MAX) pt = Q_MAX;
    if (pt < Q_MIN) pt = Q_MIN;
    return pt;
  endfunction

  function automatic pixel_result_t predict_pixel(input logic [11:0] r, input logic [11:0] c);
    pixel_result_t res;
    longint c_re, c_im, zr, zi, sq, xp;
    int unsigned n, dbl;
    c_re = axis_point(cur_re_start, cur_re_end, longint'(r), clamp_side(cur_width));
    c_im = axis_point(cur_im_start, cur_im_end, longint'(c), clamp_side(cur_height));
    zr = 0;
    zi = 0;
    for (n = 0; n < mbet_pkg::MAX_ITERATIONS; n++) begin
      // a component past 2.0 is out before the squares are looked at
      if (zr > ESC_LIM || zr < -ESC_LIM || zi > ESC_LIM || zi < -ESC_LIM) break;
      if (zr * zr + zi * zi > ESC_R2) break;
      sq = zr * zr - zi * zi;
      xp = 2 * zr * zi;
      zr = (sq >>> mbet_pkg::FRAC_BITS) + c_re;
      zi = (xp >>> mbet_pkg::FRAC_BITS) + c_im;
    end
    dbl = (510 * n) / mbet_pkg::MAX_ITERATIONS;
    res.row    = r;
    res.col    = c;
    res.steps  = 8'(n);
    res.shade0 = (dbl > 255) ? 8'd255 : 8'(dbl);
    res.shade1 = 8'((255 * n) / mbet_pkg::MAX_ITERATIONS);
    res.shade2 = res.shade1;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= PRINT_CAP) $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned exp_val);
    if (got != exp_val)
      report_mismatch($sformatf("%s got %0d want %0d (pixel %0d,%0d)",
                                name, got, exp_val, want.row, want.col));
  endtask

  // result checker: one expectation per accepted word, oldest first
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected word row %0d col %0d", row_out, col_out));
      end else begin
        want = pending_pixels.pop_front();
        check_field("row_out", 32'(row_out), 32'(want.row));
        check_field("col_out", 32'(col_out), 32'(want.col));
        check_field("escape_count", 32'(escape_count), 32'(want.steps));
        check_field("chan0", 32'(chan0), 32'(want.shade0));
        check_field("chan1", 32'(chan1), 32'(want.shade1));
        check_field("chan2", 32'(chan2), 32'(want.shade2));
        if (want.steps == 8'(mbet_pkg::MAX_ITERATIONS)) limit_hits++;
        else early_exits++;
      end
    end
  end

  // receiver stall pattern; a hold request stalls for a long fixed stretch
  initial begin : result_stall
    stall_mode_t mode;
    int unsigned run_left;
    mode = STALL_NONE;
    run_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        holds_done++;
      end
      if (run_left == 0) begin
        mode = stall_mode_t'($urandom_range(0, 3));
        run_left = $urandom_range(16, 240);
      end
      run_left--;
      case (mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HALF:  out_stall <= ($urandom_range(0, 1) == 0);
        default:     out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // offers one pixel and returns at the edge that takes it; valid stays up
  task automatic send_pixel(input logic [11:0] r, input logic [11:0] c);
    in_valid <= 1'b1;
    row      <= r;
    col      <= c;
    do @(posedge clk); while (in_stall);
    pending_pixels.insert(pending_pixels.size(), predict_pixel(r, c));
    pixels_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  // leaves cfg_valid high so back-to-back writes need no extra edge
  task automatic write_register(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    writes_done++;
    case (idx)
      mbet_pkg::CFG_RE_START:     cur_re_start = longint'($signed(data));
      mbet_pkg::CFG_RE_END:       cur_re_end   = longint'($signed(data));
      mbet_pkg::CFG_IM_START:     cur_im_start = longint'($signed(data));
      mbet_pkg::CFG_IM_END:       cur_im_end   = longint'($signed(data));
      mbet_pkg::CFG_IMAGE_WIDTH:  cur_width    = data[12:0];
      mbet_pkg::CFG_IMAGE_HEIGHT: cur_height   = data[12:0];
      default: ;
    endcase
  endtask

  task automatic set_window(input logic [31:0] rs, input logic [31:0] re_e,
                            input logic [31:0] is_s, input logic [31:0] ie,
                            input logic [31:0] w, input logic [31:0] h);
    drain();
    write_register(mbet_pkg::CFG_RE_START, rs);
    write_register(mbet_pkg::CFG_RE_END, re_e);
    write_register(mbet_pkg::CFG_IM_START, is_s);
    write_register(mbet_pkg::CFG_IM_END, ie);
    write_register(mbet_pkg::CFG_IMAGE_WIDTH, w);
    write_register(mbet_pkg::CFG_IMAGE_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] extreme_coord();
    case ($urandom_range(0, 3))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // side register data with junk above bit 12
  function automatic logic [31:0] random_side();
    int unsigned s;
    case ($urandom_range(0, 9))
      0:       s = 0;
      1:       s = 8191;
      2:       s = $urandom_range(4097, 8191);
      3:       s = 4096;
      default: s = $urandom_range(1, $urandom_range(1, 4096));
    endcase
    return ($urandom & 32'hFFFF_E000) | 32'(s);
  endfunction

  task automatic random_window();
    logic [31:0] rs, re_e, is_s, ie;
    int unsigned pick, span;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      rs = $urandom; re_e = $urandom; is_s = $urandom; ie = $urandom;
    end else if (pick == 1) begin
      rs = extreme_coord(); re_e = extreme_coord();
      is_s = extreme_coord(); ie = extreme_coord();
    end else begin
      // windows around the set, some deep zooms, some with reversed spans
      rs = 32'(-671088640 + int'($urandom_range(0, 939524096)));
      span = ($urandom_range(0, 2) == 0) ? $urandom_range(256, 1 << 22)
                                         : $urandom_range(1 << 22, 805306368);
      re_e = ($urandom_range(0, 4) == 0) ? rs - span : rs + span;
      is_s = 32'(-402653184 + int'($urandom_range(0, 805306368)));
      span = ($urandom_range(0, 2) == 0) ? $urandom_range(256, 1 << 22)
                                         : $urandom_range(1 << 22, 805306368);
      ie = ($urandom_range(0, 4) == 0) ? is_s - span : is_s + span;
    end
    set_window(rs, re_e, is_s, ie, random_side(), random_side());
  endtask

  // bursts of pixels with random gaps; most stay inside the image
  task automatic send_random_pixels(input int unsigned count);
    int unsigned burst, gap, rlim, clim;
    logic [11:0] r, c;
    burst = 0;
    rlim = clamp_side(cur_width);
    clim = clamp_side(cur_height);
    for (int unsigned i = 0; i < count; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        if ($urandom_range(0, 15) == 0) drain();
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst--;
      r = ($urandom_range(0, 4) == 0) ? 12'($urandom_range(0, 4095))
                                      : 12'($urandom_range(0, rlim - 1));
      c = ($urandom_range(0, 4) == 0) ? 12'($urandom_range(0, 4095))
                                      : 12'($urandom_range(0, clim - 1));
      send_pixel(r, c);
    end
    in_valid <= 1'b0;
  endtask

  task automatic test_reset_mapping();
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd960, 12'd960);      // c = -0.5: never escapes
    send_pixel(12'd0, 12'd960);        // c = -2: orbit sits on |z| = 2
    send_pixel(12'd1280, 12'd960);     // c = 0
    send_pixel(12'd1440, 12'd960);     // cusp at 0.25
    send_pixel(12'd1441, 12'd960);     // just past the cusp: slow escape
    send_pixel(12'd1919, 12'd1919);
    send_pixel(12'hAAA, 12'h555);
    drain();
  endtask

  task automatic test_divisor_clamp();
    // width reads as zero once upper bits are dropped; height clamps to max
    set_window(mbet_pkg::RE_START_RST, mbet_pkg::RE_END_RST,
               mbet_pkg::IM_START_RST, mbet_pkg::IM_END_RST,
               32'hFFFF_E000, 32'h0000_1FFF);
    send_pixel(12'd1, 12'd0);
    send_pixel(12'd4095, 12'd2048);    // real part saturates high
    send_pixel(12'd0, 12'd4095);
    drain();
    write_register(CFG_SPARE_6, 32'h0000_0001);
    write_register(CFG_SPARE_7, 32'hFFFF_FFFF);
    cfg_valid <= 1'b0;
    send_pixel(12'd1, 12'd2048);
    drain();
    set_window(mbet_pkg::RE_START_RST, mbet_pkg::RE_END_RST,
               mbet_pkg::IM_START_RST, mbet_pkg::IM_END_RST,
               32'h0000_1000, 32'h0000_0001);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd2048, 12'd1);
    drain();
  endtask

  task automatic test_axis_extremes();
    // full-range span on real, reversed full span on imaginary
    set_window(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
               32'd3, 32'd7);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd3);
    send_pixel(12'd2, 12'd6);
    send_pixel(12'd3, 12'd1);
    send_pixel(12'd4095, 12'd4095);    // both parts saturate
    drain();
    set_window(32'd0, 32'd0, 32'd0, 32'd0, 32'd1, 32'd4096);
    send_pixel(12'hFFF, 12'h000);
    drain();
  endtask

  task automatic test_backpressure();
    set_window(mbet_pkg::RE_START_RST, mbet_pkg::RE_END_RST,
               mbet_pkg::IM_START_RST, mbet_pkg::IM_END_RST,
               32'(mbet_pkg::SIDE_RST), 32'(mbet_pkg::SIDE_RST));
    hold_req = 1'b1;
    for (int i = 0; i < 8; i++)
      send_pixel(12'($urandom_range(0, 1919)), 12'($urandom_range(0, 1919)));
    drain();
  endtask

  task automatic test_random_windows();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      random_window();
      if (phase == RANDOM_PHASES / 2) hold_req = 1'b1;
      send_random_pixels(RANDOM_ITEMS / RANDOM_PHASES);
    end
    drain();
  endtask

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    row       <= '0;
    col       <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= mbet_pkg::CFG_RE_START;
    cfg_data  <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_mapping();
    test_divisor_clamp();
    test_axis_extremes();
    test_backpressure();
    test_random_windows();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_pixels.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_pixels.size()));

    $display("Covered %0d pixels across %0d register writes and %0d long receiver holds;",
             pixels_sent, writes_done, holds_done);
    $display("%0d pixels ran to the iteration limit, %0d escaped sooner, %0d mismatches.",
             limit_hits, early_exits, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
